@@ src/idm_pkg.sv @@
// shared types, constants and codes for the interval duration monitor
package idm_pkg;

  localparam int unsigned DEF_THREAD_SLOTS     = 16;
  localparam int unsigned DEF_MAX_INTERVAL_IDS = 16;

  localparam int unsigned IDS_W   = 5;
  localparam int unsigned IDENT_W = 32;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MEAN_W  = 48;

  // divider: 48 quotient bits, remainder wide enough for a 33-bit divisor
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned REM_W  = 33;
  localparam int unsigned STEP_W = 6;
  // mean * n + span * 256 stays below 2^81
  localparam int unsigned NUM_W  = 81;

  // slot hash folds four identity bits per cycle
  localparam logic [3:0]        HASH_STEPS = 4'd8;
  localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd48;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ID  = 2'd1,
    STAT_FOREIGN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT_GO,
    ST_SLOT_WAIT,
    ST_READ,
    ST_DECIDE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [IDENT_W-1:0]  thread_ident;
    logic [ID_W-1:0]     interval_id;
    logic [TIME_W-1:0]   time_us;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [3:0]          slot;
    logic [COUNT_W-1:0]  event_total;
    logic [MEAN_W-1:0]   mean_time;
    logic [TIME_W-1:0]   last_span;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   start_time;
    logic [COUNT_W-1:0]  event_count;
    logic [MEAN_W-1:0]   mean_duration;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

endpackage

@@ src/idm_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module idm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  idm_pkg::div_cmd_t         cmd_i,
  input  logic [idm_pkg::REM_W-1:0] rem_init_i,
  input  logic [idm_pkg::DIV_W-1:0] dividend_i,
  input  logic [idm_pkg::REM_W-1:0] divisor_i,
  output idm_pkg::div_rsp_t         rsp_o
);

  logic [idm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [idm_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [idm_pkg::DIV_W-1:0]  dvd_q, dvd_d;
  logic [idm_pkg::REM_W-1:0]  dsr_q, dsr_d;
  logic [idm_pkg::REM_W:0]    trial;
  logic [idm_pkg::REM_W+1:0]  diff;
  logic                       ge;

  assign trial = {rem_q, dvd_q[idm_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~diff[idm_pkg::REM_W+1];

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    if (cmd_i.start) begin
      cnt_d = cmd_i.steps;
      rem_d = rem_init_i;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[idm_pkg::REM_W-1:0] : trial[idm_pkg::REM_W-1:0];
      // dividend bits leave at the top, quotient bits enter at the bottom
      dvd_d = {dvd_q[idm_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.quotient = dvd_q;

endmodule

@@ src/idm_store.sv @@
// per-entry timing memory, slot owner memory and slot claim flags
module idm_store #(
  parameter int unsigned THREAD_SLOTS     = idm_pkg::DEF_THREAD_SLOTS,
  parameter int unsigned MAX_INTERVAL_IDS = idm_pkg::DEF_MAX_INTERVAL_IDS,
  localparam int unsigned ENTRY_DEPTH     = THREAD_SLOTS * MAX_INTERVAL_IDS,
  localparam int unsigned ENTRY_W         = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1,
  localparam int unsigned SLOT_W          = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ENTRY_W-1:0]          entry_addr_i,
  input  logic                        entry_we_i,
  input  idm_pkg::entry_t             entry_wdata_i,
  output idm_pkg::entry_t             entry_rdata_o,
  input  logic [SLOT_W-1:0]           slot_i,
  input  logic                        owner_we_i,
  input  logic [idm_pkg::IDENT_W-1:0] owner_wdata_i,
  output logic [idm_pkg::IDENT_W-1:0] owner_rdata_o,
  output logic                        taken_o
);

  idm_pkg::entry_t             entry_mem [ENTRY_DEPTH];
  logic [idm_pkg::IDENT_W-1:0] owner_mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0]     taken_q;

  always_ff @(posedge clk_i) begin
    if (entry_we_i) begin
      entry_mem[entry_addr_i] <= entry_wdata_i;
    end
    entry_rdata_o <= entry_mem[entry_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (owner_we_i) begin
      owner_mem[slot_i] <= owner_wdata_i;
    end
    owner_rdata_o <= owner_mem[slot_i];
  end

  // a slot stays claimed until reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (owner_we_i) begin
      taken_q[slot_i] <= 1'b1;
    end
  end

  assign taken_o = taken_q[slot_i];

endmodule

@@ src/interval_duration_monitor.sv @@
// top level: event sequencer, mean update datapath, config register and output register
//
// Begin/end events are handled one at a time. After reset the timing memory
// (THREAD_SLOTS * MAX_INTERVAL_IDS entries) is swept to zero at one entry per
// cycle, and no event is taken during the sweep; the config register can be
// written throughout. Every event first hashes its thread identity to a slot,
// (ident + 1) mod THREAD_SLOTS, by folding four identity bits per cycle with a
// constant compare and subtract. An end with a non-zero count then forms
// mean*n + span*256 on one 32x32 multiplier in two passes and runs the
// bit-serial divider for 48 quotient bits. in_stall_o stays high until the
// result has moved into the output register, which holds it while out_stall_i
// is high and lets the next event in meanwhile.
module interval_duration_monitor #(
  parameter int unsigned THREAD_SLOTS     = idm_pkg::DEF_THREAD_SLOTS,
  parameter int unsigned MAX_INTERVAL_IDS = idm_pkg::DEF_MAX_INTERVAL_IDS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  idm_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output idm_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [idm_pkg::IDS_W-1:0] cfg_data_i
);

  localparam int unsigned ENTRY_DEPTH = THREAD_SLOTS * MAX_INTERVAL_IDS;
  localparam int unsigned ENTRY_W     = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int unsigned SLOT_W      = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(ENTRY_DEPTH - 1);

  idm_pkg::state_e             state_q, state_d;
  logic [ENTRY_W-1:0]          clr_q, clr_d;
  logic [idm_pkg::IDS_W-1:0]   ids_q;
  idm_pkg::in_item_t           item_q, item_d;
  logic [SLOT_W-1:0]           slot_q, slot_d;
  logic [idm_pkg::TIME_W-1:0]  span_q, span_d;
  logic [idm_pkg::NUM_W-1:0]   num_q, num_d;
  idm_pkg::out_item_t          res_q, res_d;
  logic                        out_valid_q;
  idm_pkg::out_item_t          out_q;
  logic [idm_pkg::IDENT_W-1:0] hash_q, hash_d;
  logic [7:0]                  hrem_q, hrem_d;
  logic [3:0]                  hcnt_q, hcnt_d;
  logic [11:0]                 fold;

  idm_pkg::div_cmd_t           div_cmd;
  idm_pkg::div_rsp_t           div_rsp;
  logic [idm_pkg::REM_W-1:0]   div_rem_init;
  logic [idm_pkg::DIV_W-1:0]   div_dividend;
  logic [idm_pkg::REM_W-1:0]   div_divisor;

  logic [ENTRY_W-1:0]          entry_idx;
  logic [ENTRY_W-1:0]          entry_addr;
  logic                        entry_we;
  idm_pkg::entry_t             entry_wdata;
  idm_pkg::entry_t             entry_rd;
  logic                        owner_we;
  logic [idm_pkg::IDENT_W-1:0] owner_rd;
  logic                        taken;

  logic                        id_ok;
  logic                        owner_match;
  logic [7:0]                  slot_wide;
  logic [31:0]                 mul_a;
  logic [63:0]                 mul_p;
  logic [idm_pkg::COUNT_W-1:0] cnt_next;
  logic [idm_pkg::MEAN_W-1:0]  mean_new;
  logic                        out_load;

  idm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp)
  );

  idm_store #(
    .THREAD_SLOTS     (THREAD_SLOTS),
    .MAX_INTERVAL_IDS (MAX_INTERVAL_IDS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_addr_i  (entry_addr),
    .entry_we_i    (entry_we),
    .entry_wdata_i (entry_wdata),
    .entry_rdata_o (entry_rd),
    .slot_i        (slot_q),
    .owner_we_i    (owner_we),
    .owner_wdata_i (item_q.thread_ident),
    .owner_rdata_o (owner_rd),
    .taken_o       (taken)
  );

  // id must lie in 1..min(ids_in_use, MAX_INTERVAL_IDS)
  assign id_ok = (item_q.interval_id != 8'd0)
              && (item_q.interval_id <= {3'b000, ids_q})
              && (item_q.interval_id <= 8'(MAX_INTERVAL_IDS));

  assign entry_idx = ENTRY_W'(slot_q) * ENTRY_W'(MAX_INTERVAL_IDS)
                   + ENTRY_W'(item_q.interval_id - 8'd1);

  assign owner_match = (owner_rd == item_q.thread_ident);
  assign slot_wide   = 8'(slot_q);

  // next nibble into the running remainder, reduced by shifted copies of the slot count
  always_comb begin
    fold = {hrem_q, hash_q[idm_pkg::IDENT_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (fold >= 12'(THREAD_SLOTS << k)) begin
        fold = fold - 12'(THREAD_SLOTS << k);
      end
    end
  end

  // shared 32x32 multiplier, low then high part of the stored mean
  assign mul_a = (state_q == idm_pkg::ST_MUL_HI)
               ? {16'h0000, entry_rd.mean_duration[47:32]}
               : entry_rd.mean_duration[31:0];
  assign mul_p = mul_a * entry_rd.event_count;

  assign cnt_next = (entry_rd.event_count == '1) ? entry_rd.event_count
                                                 : entry_rd.event_count + 1'b1;
  assign mean_new = (entry_rd.event_count == '0) ? {span_q, 8'h00} : div_rsp.quotient;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    item_d       = item_q;
    slot_d       = slot_q;
    span_d       = span_q;
    num_d        = num_q;
    res_d        = res_q;
    hash_d       = hash_q;
    hrem_d       = hrem_q;
    hcnt_d       = hcnt_q;
    div_cmd      = '0;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = '0;
    entry_addr   = entry_idx;
    entry_we     = 1'b0;
    entry_wdata  = '0;
    owner_we     = 1'b0;
    unique case (state_q)
      idm_pkg::ST_CLEAR: begin
        entry_addr = clr_q;
        entry_we   = 1'b1;
        if (clr_q == ENTRY_LAST) begin
          state_d = idm_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      idm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = idm_pkg::ST_SLOT_GO;
        end
      end
      idm_pkg::ST_SLOT_GO: begin
        // (ident + 1) mod THREAD_SLOTS, top nibble first
        hash_d  = item_q.thread_ident + 32'd1;
        hrem_d  = '0;
        hcnt_d  = idm_pkg::HASH_STEPS;
        state_d = idm_pkg::ST_SLOT_WAIT;
      end
      idm_pkg::ST_SLOT_WAIT: begin
        hash_d = {hash_q[idm_pkg::IDENT_W-5:0], 4'h0};
        hrem_d = fold[7:0];
        hcnt_d = hcnt_q - 1'b1;
        if (hcnt_q == 4'd1) begin
          slot_d  = fold[SLOT_W-1:0];
          state_d = idm_pkg::ST_READ;
        end
      end
      idm_pkg::ST_READ: begin
        state_d = idm_pkg::ST_DECIDE;
      end
      idm_pkg::ST_DECIDE: begin
        res_d      = '0;
        res_d.slot = slot_wide[3:0];
        if (!id_ok) begin
          res_d.status = idm_pkg::STAT_BAD_ID;
          state_d      = idm_pkg::ST_DONE;
        end else if (item_q.kind == idm_pkg::KIND_BEGIN) begin
          if (taken && !owner_match) begin
            res_d.status = idm_pkg::STAT_FOREIGN;
          end else begin
            owner_we                  = ~taken;
            entry_we                  = 1'b1;
            entry_wdata               = entry_rd;
            entry_wdata.start_time    = item_q.time_us;
            res_d.event_total         = entry_rd.event_count;
            res_d.mean_time           = entry_rd.mean_duration;
          end
          state_d = idm_pkg::ST_DONE;
        end else if (!taken || !owner_match) begin
          res_d.status = idm_pkg::STAT_FOREIGN;
          state_d      = idm_pkg::ST_DONE;
        end else begin
          span_d = item_q.time_us - entry_rd.start_time;
          if (entry_rd.event_count == '0) begin
            state_d = idm_pkg::ST_WRITE;
          end else begin
            state_d = idm_pkg::ST_MUL_LO;
          end
        end
      end
      idm_pkg::ST_MUL_LO: begin
        num_d   = idm_pkg::NUM_W'(mul_p) + idm_pkg::NUM_W'({span_q, 8'h00});
        state_d = idm_pkg::ST_MUL_HI;
      end
      idm_pkg::ST_MUL_HI: begin
        num_d   = num_q + {mul_p[48:0], 32'h0000_0000};
        state_d = idm_pkg::ST_DIV_GO;
      end
      idm_pkg::ST_DIV_GO: begin
        // numerator below (n+1) * 2^48, so its top bits already are a remainder
        div_cmd.start = 1'b1;
        div_cmd.steps = idm_pkg::MEAN_STEPS;
        div_rem_init  = num_q[idm_pkg::NUM_W-1:idm_pkg::DIV_W];
        div_dividend  = num_q[idm_pkg::DIV_W-1:0];
        div_divisor   = {1'b0, entry_rd.event_count} + 33'd1;
        state_d       = idm_pkg::ST_DIV_WAIT;
      end
      idm_pkg::ST_DIV_WAIT: begin
        if (!div_rsp.busy) begin
          state_d = idm_pkg::ST_WRITE;
        end
      end
      idm_pkg::ST_WRITE: begin
        entry_we                  = 1'b1;
        entry_wdata.start_time    = '0;
        entry_wdata.event_count   = cnt_next;
        entry_wdata.mean_duration = mean_new;
        res_d.status              = idm_pkg::STAT_OK;
        res_d.event_total         = cnt_next;
        res_d.mean_time           = mean_new;
        res_d.last_span           = span_q;
        state_d                   = idm_pkg::ST_DONE;
      end
      idm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = idm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = idm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == idm_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idm_pkg::ST_CLEAR;
      clr_q       <= '0;
      ids_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ids_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    span_q <= span_d;
    num_q  <= num_d;
    res_q  <= res_d;
    hash_q <= hash_d;
    hrem_q <= hrem_d;
    hcnt_q <= hcnt_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != idm_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new result only ever comes from the hand-off state
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == idm_pkg::ST_DONE))
    else $error("result register loaded outside hand-off");

  // divider is finished before another event can come in
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == idm_pkg::ST_IDLE) |-> !div_rsp.busy)
    else $error("divider still running while idle");

  // refused events carry no count, mean or span
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != idm_pkg::STAT_OK))
      |-> (out_data_o.event_total == '0) && (out_data_o.mean_time == '0)
          && (out_data_o.last_span == '0))
    else $error("refused event carries data");

  // the entry write port is only used during the sweep, in the decision state or in the write state
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_we |-> (state_q == idm_pkg::ST_CLEAR) || (state_q == idm_pkg::ST_DECIDE)
                 || (state_q == idm_pkg::ST_WRITE))
    else $error("unexpected timing memory write");

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the interval duration monitor
module testbench;
  import idm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned SLOTS        = 16;
  localparam int unsigned IDS          = 16;
  localparam int unsigned PRINT_LIMIT  = 40;

  logic             clk;
  logic             rst_n;
  logic             ev_valid;
  logic             ev_stall;
  in_item_t         ev_data;
  logic             rep_valid;
  logic             rep_stall;
  out_item_t        rep_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDS_W-1:0] cfg_data;

  interval_duration_monitor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_data),
    .out_valid_o (rep_valid),
    .out_stall_i (rep_stall),
    .out_data_o  (rep_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // timing table kept alongside the block
  bit [IDENT_W-1:0] owner_ident [SLOTS];
  bit               owner_known [SLOTS];
  bit [TIME_W-1:0]  begin_stamp [SLOTS*IDS];
  bit [COUNT_W-1:0] done_count  [SLOTS*IDS];
  bit [MEAN_W-1:0]  avg_span    [SLOTS*IDS];
  bit [IDS_W-1:0]   ids_setting;

  out_item_t   awaited_reports [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned events_sent;
  int unsigned reports_checked;
  int unsigned intervals_timed;
  int unsigned begins_taken;
  int unsigned bad_id_count;
  int unsigned foreign_count;
  int unsigned settings_written;
  int unsigned stall_left;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
             awaited_reports.size());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic int unsigned ids_accepted();
    return (ids_setting > IDS) ? IDS : ids_setting;
  endfunction

  function automatic void predict_interval_result(input in_item_t ev);
    out_item_t        r;
    bit [IDENT_W-1:0] bumped;
    bit [3:0]         s;
    int unsigned      e;
    bit [COUNT_W-1:0] n;
    bit [TIME_W-1:0]  span;
    bit [127:0]       num;
    bit [127:0]       quo;
    r = '0;
    bumped = ev.thread_ident + 32'd1;
    s = bumped[3:0];
    r.slot = s;
    if (ev.interval_id == 0 || ev.interval_id > ids_accepted()) begin
      r.status = STAT_BAD_ID;
      bad_id_count++;
    end else begin
      e = s * IDS + ev.interval_id - 1;
      if (ev.kind == KIND_BEGIN) begin
        // first begin in a free slot claims it for good
        if (!owner_known[s]) begin
          owner_known[s] = 1'b1;
          owner_ident[s] = ev.thread_ident;
        end
        if (owner_ident[s] != ev.thread_ident) begin
          r.status = STAT_FOREIGN;
          foreign_count++;
        end else begin
          begin_stamp[e] = ev.time_us;
          r.event_total = done_count[e];
          r.mean_time = avg_span[e];
          begins_taken++;
        end
      end else if (!owner_known[s] || owner_ident[s] != ev.thread_ident) begin
        r.status = STAT_FOREIGN;
        foreign_count++;
      end else begin
        n = done_count[e];
        span = ev.time_us - begin_stamp[e];
        begin_stamp[e] = '0;
        if (n == 0) begin
          avg_span[e] = {span, 8'h00};
        end else begin
          num = 128'(avg_span[e]) * 128'(n) + (128'(span) << 8);
          quo = num / (128'(n) + 128'd1);
          avg_span[e] = quo[MEAN_W-1:0];
        end
        if (n != '1) done_count[e] = n + 1;
        r.event_total = done_count[e];
        r.mean_time = avg_span[e];
        r.last_span = span;
        intervals_timed++;
      end
    end
    awaited_reports.push_back(r);
  endfunction

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (awaited_reports.size() == 0) begin
      report_mismatch("result with nothing awaited, slot", 64'(got.slot), 64'd0);
      return;
    end
    want = awaited_reports.pop_front();
    reports_checked++;
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.slot !== want.slot)
      report_mismatch("slot", 64'(got.slot), 64'(want.slot));
    if (got.event_total !== want.event_total)
      report_mismatch("event_total", 64'(got.event_total), 64'(want.event_total));
    if (got.mean_time !== want.mean_time)
      report_mismatch("mean_time", 64'(got.mean_time), 64'(want.mean_time));
    if (got.last_span !== want.last_span)
      report_mismatch("last_span", 64'(got.last_span), 64'(want.last_span));
  endtask

  // result side: each result is held off for a drawn number of valid cycles
  always @(posedge clk) begin
    if (rst_n && rep_valid && !rep_stall) begin
      check_report(rep_data);
      stall_left = calm ? 0 : $urandom_range(0, 7);
      rep_stall <= (stall_left != 0);
    end else if (rst_n && rep_valid && rep_stall) begin
      stall_left--;
      rep_stall <= (stall_left != 0);
    end
  end

  function automatic logic [TIME_W-1:0] random40();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t make_event(input kind_e k, input logic [IDENT_W-1:0] who,
                                          input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] t);
    in_item_t ev;
    ev.kind = k;
    ev.thread_ident = who;
    ev.interval_id = id;
    ev.time_us = t;
    return ev;
  endfunction

  // owner of a slot, or a fresh identity that hashes to it
  function automatic logic [IDENT_W-1:0] owner_for_slot(input logic [3:0] s);
    logic [IDENT_W-1:0] who;
    if (owner_known[s]) return owner_ident[s];
    who = $urandom;
    who[3:0] = s - 4'd1;
    return who;
  endfunction

  // valid stays high after a transfer when the next event follows at once
  task automatic send_event(input in_item_t ev);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_data <= ev;
    do @(posedge clk); while (ev_stall);
    events_sent++;
    predict_interval_result(ev);
  endtask

  task automatic drain_reports();
    ev_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_ids_in_use(input logic [IDS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ids_setting = v;
    settings_written++;
    @(posedge clk);
  endtask

  task automatic test_disabled();
    // reset value of the register refuses everything
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd1, 40'd0));
    drain_reports();
    write_ids_in_use(5'd0);
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd1, 40'd10));
  endtask

  task automatic test_interval_basics();
    drain_reports();
    write_ids_in_use(5'd16);
    // all-ones identity wraps to slot 0
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd1, 40'd0));
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd1, 40'd100));
    // second end finds the start time cleared
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd1, 40'd250));
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd1, 40'd40));
    // span wraps past the top of the time range
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd16, 40'hFF_FFFF_FFFF));
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd16, 40'd5));
    // end with no begin on record
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd2, 40'd1000));
    send_event(make_event(KIND_BEGIN, 32'h0000_0000, 8'd8, 40'hFF_FFFF_FFFF));
  endtask

  task automatic test_refused_ids();
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd0, 40'd7));
    send_event(make_event(KIND_END, 32'hFFFF_FFFF, 8'd17, 40'd7));
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd255, 40'd7));
  endtask

  task automatic test_foreign_owner();
    send_event(make_event(KIND_BEGIN, 32'h0000_000F, 8'd1, 40'd500));
    send_event(make_event(KIND_END, 32'h0000_000F, 8'd1, 40'd900));
    // slot 5 is still free, so an end has no owner to match
    send_event(make_event(KIND_END, 32'h0000_0004, 8'd3, 40'd20));
    send_event(make_event(KIND_BEGIN, 32'h8000_0004, 8'd3, 40'd30));
    send_event(make_event(KIND_BEGIN, 32'h0000_0004, 8'd3, 40'd40));
  endtask

  task automatic test_register_range();
    drain_reports();
    // above the id count the register is clamped
    write_ids_in_use(5'd31);
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd16, 40'd123));
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd17, 40'd123));
    drain_reports();
    write_ids_in_use(5'd5);
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd5, 40'd321));
    send_event(make_event(KIND_BEGIN, 32'hFFFF_FFFF, 8'd6, 40'd321));
  endtask

  task automatic send_interval_sequence();
    logic [3:0]         s;
    logic [IDENT_W-1:0] who;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  t0;
    logic [TIME_W-1:0]  dt;
    // a few busy slots so that counts build up
    s = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    who = owner_for_slot(s);
    id = ID_W'($urandom_range(1, ids_accepted()));
    t0 = random40();
    send_event(make_event(KIND_BEGIN, who, id, t0));
    if ($urandom_range(0, 4) == 0) begin
      t0 = t0 + TIME_W'($urandom_range(0, 5000));
      send_event(make_event(KIND_BEGIN, who, id, t0));
    end
    dt = ($urandom_range(0, 7) == 0) ? random40() : TIME_W'($urandom_range(0, 250000));
    send_event(make_event(KIND_END, who, id, t0 + dt));
  endtask

  task automatic send_noise();
    logic [IDENT_W-1:0] who;
    logic [ID_W-1:0]    id;
    case ($urandom_range(0, 3))
      0: id = ID_W'($urandom_range(0, 255));
      1: id = '0;
      2: id = ID_W'(ids_accepted() + 1);
      default: id = (ids_accepted() == 0) ? 8'd1 : ID_W'($urandom_range(1, ids_accepted()));
    endcase
    who = $urandom_range(0, 1) ? IDENT_W'($urandom) : owner_for_slot(4'($urandom_range(0, 15)));
    send_event(make_event($urandom_range(0, 1) ? KIND_END : KIND_BEGIN, who, id, random40()));
  endtask

  task automatic test_random_traffic();
    logic [IDS_W-1:0] plan [8];
    int unsigned      target;
    int               p;
    bit               paused;
    plan = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd16, 5'd17, 5'd8, 5'd16};
    plan[6] = IDS_W'($urandom_range(2, 15));
    for (p = 0; p < 8; p++) begin
      drain_reports();
      write_ids_in_use(plan[p]);
      calm = ($urandom_range(0, 3) == 0);
      target = events_sent + ((plan[p] == 0) ? 20 : 119);
      paused = 1'b0;
      while (events_sent < target) begin
        if (!paused && events_sent + 60 >= target) begin
          // hold off the sender until every result is back
          drain_reports();
          paused = 1'b1;
          calm = !calm;
        end
        if (ids_accepted() != 0 && $urandom_range(0, 4) != 0) send_interval_sequence();
        else send_noise();
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    ev_valid <= 1'b0;
    ev_data <= '0;
    rep_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_disabled();
    test_interval_basics();
    test_refused_ids();
    test_foreign_owner();
    test_register_range();
    test_random_traffic();

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d events sent, %0d results checked over %0d register writes",
             events_sent, reports_checked, settings_written);
    $display("%0d intervals timed, %0d begins taken, %0d bad ids, %0d refused by owner",
             intervals_timed, begins_taken, bad_id_count, foreign_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ interval_duration_monitor.f @@
src/idm_pkg.sv
src/idm_div.sv
src/idm_store.sv
src/interval_duration_monitor.sv
dv/testbench.sv
